[sv/ehrd_pkg.sv]
`timescale 1ns / 1ps
package ehrd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 20;
  localparam int RATE_W   = 8;
  localparam int THR_W    = 12;
  localparam int REFR_W   = 16;
  localparam int GAIN_W   = 9;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DIVR_W   = 11;
  localparam int REM_W    = 16;
  localparam int CNT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd3;

  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 12'd2048;
  localparam logic [REFR_W-1:0] REFRACTORY_RST = 16'd250;
  localparam logic [GAIN_W-1:0] GAIN_RST       = 9'd26;
  localparam logic [GAIN_W-1:0] GAIN_ONE       = 9'd256;

  localparam logic [TIME_W-1:0] MIN_INTERVAL_MS = 32'd300;
  localparam logic [TIME_W-1:0] MAX_INTERVAL_MS = 32'd2000;
  localparam logic [REM_W-1:0]  MS_PER_MINUTE   = 16'd60000;
  localparam logic [RATE_W-1:0] MIN_BPM         = 8'd30;
  localparam logic [RATE_W-1:0] MAX_BPM         = 8'd200;
  localparam logic [CNT_W-1:0]  DIV_STEPS_LAST  = 3'd7;

  typedef struct packed {
    logic capture;
    logic mul;
    logic upd;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } sts_t;

endpackage

[sv/ehrd_ctrl.sv]
`timescale 1ns / 1ps
module ehrd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output ehrd_pkg::cmd_t cmd,
  input  ehrd_pkg::sts_t sts
);
  import ehrd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = sts.need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[sv/ehrd_dp.sv]
`timescale 1ns / 1ps
module ehrd_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  ehrd_pkg::cmd_t                    cmd,
  output ehrd_pkg::sts_t                    sts,
  input  logic [ehrd_pkg::SAMPLE_W-1:0]     in_sample,
  input  logic [ehrd_pkg::TIME_W-1:0]       in_time,
  input  logic                              cfg_we,
  input  logic [ehrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ehrd_pkg::CFG_W-1:0]        cfg_data,
  output logic                              out_beat,
  output logic [ehrd_pkg::RATE_W-1:0]       out_rate,
  output logic [ehrd_pkg::SAMPLE_W-1:0]     out_level
);
  import ehrd_pkg::*;

  logic [THR_W-1:0]    threshold;
  logic [REFR_W-1:0]   refractory;
  logic [GAIN_W-1:0]   gain;
  logic                enable;

  logic [LEVEL_W-1:0]  level;
  logic                primed;
  logic [TIME_W-1:0]   last_beat;
  logic [TIME_W-1:0]   prev_beat;
  logic [RATE_W-1:0]   rate;

  logic [SAMPLE_W-1:0] sample_r;
  logic [TIME_W-1:0]   time_r;
  logic signed [30:0]  prod_r;
  logic                beat_r;
  logic [REM_W-1:0]    rem;
  logic [DIVR_W-1:0]   divisor;
  logic [CNT_W-1:0]    cnt;

  logic [GAIN_W-1:0]   gain_eff;
  logic signed [20:0]  diff;
  logic signed [30:0]  prod;
  logic signed [31:0]  acc;
  logic [LEVEL_W-1:0]  level_new;
  logic [TIME_W-1:0]   since_last;
  logic [TIME_W-1:0]   interval;
  logic                in_range;
  logic                beat_hit;
  logic [17:0]         trial;
  logic                fits;

  assign gain_eff = gain[GAIN_W-1] ? GAIN_ONE : gain;
  assign diff     = $signed({1'b0, sample_r, 8'b0}) - $signed({1'b0, level});
  assign prod     = $signed({1'b0, gain_eff}) * diff;
  assign acc      = $signed({4'b0, level, 8'b0}) + $signed({prod_r[30], prod_r})
                    + 32'sd128;
  assign level_new = primed ? acc[27:8] : {sample_r, 8'b0};

  assign since_last = time_r - last_beat;
  assign interval   = time_r - prev_beat;
  assign in_range   = (interval >= MIN_INTERVAL_MS) && (interval <= MAX_INTERVAL_MS);
  assign beat_hit   = (level_new > {threshold, 8'b0})
                      && (since_last > {16'b0, refractory});

  assign sts.need_div = enable && beat_hit && (prev_beat != '0) && in_range;
  assign sts.div_last = (cnt == '0);

  assign trial = {7'b0, divisor} << cnt;
  assign fits  = {2'b0, rem} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RST;
      refractory <= REFRACTORY_RST;
      gain       <= GAIN_RST;
      enable     <= 1'b1;
      level      <= '0;
      primed     <= 1'b0;
      last_beat  <= '0;
      prev_beat  <= '0;
      rate       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD:  threshold  <= cfg_data[THR_W-1:0];
          REG_REFRACTORY: refractory <= cfg_data[REFR_W-1:0];
          REG_GAIN:       gain       <= cfg_data[GAIN_W-1:0];
          REG_ENABLE:     enable     <= cfg_data[0];
          default:        ;
        endcase
      end
      if (cmd.upd && enable) begin
        level  <= level_new;
        primed <= 1'b1;
        if (beat_hit) begin
          last_beat <= time_r;
          prev_beat <= time_r;
          if (prev_beat != '0) begin
            rate <= '0;
          end
        end
      end
      if (cmd.div_step) begin
        rate <= {rate[RATE_W-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      time_r   <= in_time;
    end
    if (cmd.mul) begin
      prod_r <= prod;
    end
    if (cmd.upd) begin
      beat_r  <= enable && beat_hit;
      rem     <= MS_PER_MINUTE;
      divisor <= interval[DIVR_W-1:0];
      cnt     <= DIV_STEPS_LAST;
    end
    if (cmd.div_step) begin
      if (fits) begin
        rem <= rem - trial[REM_W-1:0];
      end
      cnt <= cnt - 1'b1;
    end
    if (cmd.out_load) begin
      out_beat  <= beat_r;
      out_rate  <= (enable && (rate >= MIN_BPM) && (rate <= MAX_BPM)) ? rate : '0;
      out_level <= level[LEVEL_W-1:8];
    end
  end

endmodule

[sv/ecg_heartbeat_rate_detector.sv]
`timescale 1ns / 1ps
// ECG heartbeat rate detector.
// Input stream s_*: one word per ECG sample with its millisecond timestamp.
// Output stream m_*: one word per input word with the beat flag, the current
// heart rate in bpm (0 when unknown) and the integer smoothed level.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 threshold, 1 refractory ms, 2 smoothing gain, 3 enable); write only
// while no sample is in flight.
// Each sample is captured, multiplied and filtered, then loaded into the
// output register; when a beat triggers the rate update, the bit-serial
// 60000 / interval divider runs before the load, one quotient bit per cycle,
// for an 8-bit rate. A new sample is taken once the previous one has been
// handed to the output register.
// The output register holds a finished word while the receiver stalls; the
// next sample is accepted and processed meanwhile and waits at the end of its
// computation until the output register frees up.
// Synchronous reset restores the register defaults, clears the filter and
// the beat history and drops any word in flight.
module ecg_heartbeat_rate_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // sample[11:0], time_ms[43:12], zero[47:44]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // beat[0], heart_rate[8:1], smoothed_level[20:9], zero
  input  logic        cfg_we,
  input  logic [ehrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ehrd_pkg::CFG_W-1:0]     cfg_data
);
  import ehrd_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic                out_beat;
  logic [RATE_W-1:0]   out_rate;
  logic [SAMPLE_W-1:0] out_level;

  ehrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ehrd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_sample (s_tdata[11:0]),
    .in_time   (s_tdata[43:12]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_beat  (out_beat),
    .out_rate  (out_rate),
    .out_level (out_level)
  );

  assign m_tdata = {3'b0, out_level, out_rate, out_beat};

endmodule

[sv/ehrd_checker.sv]
`timescale 1ns / 1ps
module ehrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second sample taken while one is in work");

  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:1] == 8'd0)
                 || ((m_tdata[8:1] >= 8'd30) && (m_tdata[8:1] <= 8'd200)))
    else $error("heart rate outside 30..200 and not zero");

endmodule

bind ecg_heartbeat_rate_detector ehrd_checker u_chk (.*);
